// ===== hdl/ptg_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the tone generator.
package ptg_pkg;

    // Field widths
    localparam int FREQ_BITS   = 16;
    localparam int DUR_BITS    = 28;
    localparam int FRAC_BITS   = 16;
    localparam int SCALE_BITS  = 24;
    localparam int SAMPLE_BITS = 16;

    // Phase and table geometry (table depth is a power of two)
    localparam int PHASE_BITS     = 32;
    localparam int QUAD_BITS      = PHASE_BITS - 2;
    localparam int SINE_DEPTH     = 1024;
    localparam int SINE_ADDR_BITS = $clog2(SINE_DEPTH);

    // Tone length limit and sample counter width
    localparam int MAX_TONE_SAMPLES = 4095;
    localparam int COUNT_BITS       = $clog2(MAX_TONE_SAMPLES + 1);
    localparam int RAW_COUNT_BITS   = DUR_BITS + 1 - FRAC_BITS;

    // Command queue between front and back
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

    // Output buffer depth (two entries cover the registered table read)
    localparam int OBUF_DEPTH = 2;

    localparam logic [SCALE_BITS-1:0]         PHASE_SCALE_RESET = 24'd44739;
    localparam logic signed [SAMPLE_BITS-1:0] AMPLITUDE         = 16'sd32767;

    // Table build constants: pi in Q30 and ceil(2^64 / ((2n)(2n+1))) for the Taylor terms;
    // the reciprocal product is exact for every dividend below 2^33
    localparam longint unsigned PI_Q30       = 64'd3373259426;
    localparam logic [7:0][63:0] TAYLOR_RECIP = {
        64'hFFFF_FFFF_FFFF_FFFF / 64'd272 + 64'd1,
        64'hFFFF_FFFF_FFFF_FFFF / 64'd210 + 64'd1,
        64'hFFFF_FFFF_FFFF_FFFF / 64'd156 + 64'd1,
        64'hFFFF_FFFF_FFFF_FFFF / 64'd110 + 64'd1,
        64'hFFFF_FFFF_FFFF_FFFF / 64'd72  + 64'd1,
        64'hFFFF_FFFF_FFFF_FFFF / 64'd42  + 64'd1,
        64'hFFFF_FFFF_FFFF_FFFF / 64'd20  + 64'd1,
        64'hFFFF_FFFF_FFFF_FFFF / 64'd6   + 64'd1};

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic                  is_load;
        logic [PHASE_BITS-1:0] incr;
        logic [COUNT_BITS-1:0] count;
    } t_cmd;

    typedef logic [SINE_DEPTH-1:0][SAMPLE_BITS-1:0] t_sine_rom;

    // Build floor(32767 * sin(pi/2 * k / depth)) in Q30 fixed point
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom         rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   prod;
        longint unsigned   v;
        longint            s;
        logic [127:0]      wide;
        rom = '0;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            x    = (PI_Q30 * longint'(k)) >> (SINE_ADDR_BITS + 1);
            x2   = (x * x) >> 30;
            term = x;
            s    = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                prod = (term * x2) >> 30;
                wide = 128'(prod) * 128'(TAYLOR_RECIP[n-1]);
                term = wide[127:64];
                if ((n & 1) == 1) begin
                    s = s - longint'(term);
                end else begin
                    s = s + longint'(term);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            v = (longint'(s) * 64'd32767) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[k] = v[SAMPLE_BITS-1:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// ===== hdl/phase_continuous_tone_generator.sv =====
// An accepted tick passes through the command queue, the registered sine RAM read and the
// output buffer. Throughput: one item per cycle, loads and ticks alike, though a tick that
// issues a sample waits for buffer room; the sine RAM read port takes one lookup per cycle
// and the two-entry output buffer absorbs output stalls. Reset: synchronous active low;
// clears phase, step, sample count and carry, sets the scale register to 44739, then loads
// the quarter-wave sine RAM, stalling input items (configuration writes are still taken).
module phase_continuous_tone_generator
    import ptg_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [FREQ_BITS-1:0]          i_tone_frequency,
    input  logic [DUR_BITS-1:0]           i_tone_duration,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_last_of_tone,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [SCALE_BITS-1:0]         i_cfg_data
);

    logic fill_busy;
    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // Accept and classify items
    ptg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_tone_frequency (i_tone_frequency),
        .i_tone_duration  (i_tone_duration),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_fill_busy      (fill_busy),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_cmd            (front_cmd)
    );

    // Decouple front and back
    ptg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Generate samples
    ptg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_q_pop        (pop),
        .o_fill_busy    (fill_busy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample       (o_sample),
        .o_last_of_tone (o_last_of_tone)
    );

endmodule

// ===== hdl/ptg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/ptg_front.sv =====
// Front end: accepts items, holds the scale register and fraction carry, builds commands.
module ptg_front
    import ptg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_opcode,
    input  logic [FREQ_BITS-1:0]  i_tone_frequency,
    input  logic [DUR_BITS-1:0]   i_tone_duration,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SCALE_BITS-1:0] i_cfg_data,
    input  logic                  i_fill_busy,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [SCALE_BITS-1:0]           r_phase_scale;
    logic [FRAC_BITS-1:0]            r_carry;
    logic                            is_load;
    logic [DUR_BITS:0]               total;
    logic [RAW_COUNT_BITS-1:0]       count_raw;
    logic [COUNT_BITS-1:0]           count_sat;
    logic [FREQ_BITS+SCALE_BITS-1:0] product;

    // Hold off items while the table loads or the queue is full
    assign o_stall     = i_fill_busy || i_q_full;
    assign o_push      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Classify the item and work out tone length and phase step
    always_comb begin
        is_load   = (t_opcode'(i_opcode) == OP_LOAD);
        total     = {1'b0, i_tone_duration} + (DUR_BITS + 1)'(r_carry);
        count_raw = total[DUR_BITS:FRAC_BITS];
        if (count_raw > RAW_COUNT_BITS'(MAX_TONE_SAMPLES)) begin
            count_sat = COUNT_BITS'(MAX_TONE_SAMPLES);
        end else begin
            count_sat = COUNT_BITS'(count_raw);
        end
        product       = i_tone_frequency * r_phase_scale;
        o_cmd.is_load = is_load;
        o_cmd.incr    = PHASE_BITS'(product);
        o_cmd.count   = count_sat;
    end

    // Scale register and carried fraction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_scale <= PHASE_SCALE_RESET;
            r_carry       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_phase_scale <= i_cfg_data;
            end
            if (o_push && is_load) begin
                r_carry <= total[FRAC_BITS-1:0];
            end
        end
    end

endmodule

// ===== hdl/ptg_queue.sv =====
// Short command queue between the front end and the sample engine.
module ptg_queue
    import ptg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                    r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wptr;
    logic [QUEUE_PTR_BITS-1:0] r_rptr;
    logic [QUEUE_PTR_BITS:0]   r_cnt;
    logic [QUEUE_PTR_BITS:0]   n_cnt;

    assign o_full  = (r_cnt == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_entry[r_rptr];

    // Track fill level
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> (!i_push || i_pop))
        else $error("command queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command queue popped while empty");

endmodule

// ===== hdl/ptg_back.sv =====
// Sample engine: tone state, phase accumulator, sine table lookup and output buffer.
module ptg_back
    import ptg_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  t_cmd                          i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_fill_busy,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_last_of_tone
);

    // Table load after reset
    logic                      r_filling;
    logic [SINE_ADDR_BITS-1:0] r_fill_addr;

    // Tone state
    logic [PHASE_BITS-1:0]     r_phase;
    logic [PHASE_BITS-1:0]     n_phase;
    logic [PHASE_BITS-1:0]     r_incr;
    logic [PHASE_BITS-1:0]     n_incr;
    logic [COUNT_BITS-1:0]     r_left;
    logic [COUNT_BITS-1:0]     n_left;

    // Table read stage
    logic                      r_rd_valid;
    logic                      r_rd_neg;
    logic                      r_rd_max;
    logic                      r_rd_last;
    logic [SAMPLE_BITS-1:0]    rom_data;
    logic [1:0]                quad;
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [SINE_ADDR_BITS-1:0] rd_addr;
    logic                      issue;
    logic                      room;

    // Output buffer
    logic signed [SAMPLE_BITS-1:0] r_ob_sample [OBUF_DEPTH];
    logic                          r_ob_last   [OBUF_DEPTH];
    logic                          r_ob_wptr;
    logic                          r_ob_rptr;
    logic [1:0]                    r_ob_cnt;
    logic                          ob_pop;
    logic signed [SAMPLE_BITS-1:0] mag;
    logic signed [SAMPLE_BITS-1:0] sample;

    assign o_fill_busy = r_filling;

    ptg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (SINE_DEPTH)
    ) u_sine_ram (
        .i_clk   (i_clk),
        .i_we    (r_filling),
        .i_waddr (r_fill_addr),
        .i_wdata (SINE_ROM[r_fill_addr]),
        .i_raddr (rd_addr),
        .o_rdata (rom_data)
    );

    // Split phase into quadrant and table index; mirror odd quadrants
    always_comb begin
        quad    = r_phase[PHASE_BITS-1 -: 2];
        idx     = r_phase[QUAD_BITS-1 -: SINE_ADDR_BITS];
        rd_addr = quad[0] ? (SINE_ADDR_BITS'(0) - idx) : idx;
    end

    // Room downstream counts the read in flight and this cycle's output take
    assign ob_pop = o_valid && !i_stall;
    assign room   = (3'(r_ob_cnt) + 3'(r_rd_valid)) < (3'(OBUF_DEPTH) + 3'(ob_pop));

    // Execute the head command: load a tone, drop an idle tick, or issue a sample when there is room
    always_comb begin
        o_q_pop = 1'b0;
        issue   = 1'b0;
        n_phase = r_phase;
        n_incr  = r_incr;
        n_left  = r_left;
        if (!r_filling && i_q_valid) begin
            if (i_q_cmd.is_load) begin
                o_q_pop = 1'b1;
                n_incr  = i_q_cmd.incr;
                n_left  = i_q_cmd.count;
            end else if (r_left == '0) begin
                o_q_pop = 1'b1;
            end else if (room) begin
                o_q_pop = 1'b1;
                issue   = 1'b1;
                n_phase = r_phase + r_incr;
                n_left  = r_left - 1'b1;
            end
        end
    end

    // Tone state and fill sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filling   <= 1'b1;
            r_fill_addr <= '0;
            r_phase     <= '0;
            r_incr      <= '0;
            r_left      <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (r_filling) begin
                r_fill_addr <= r_fill_addr + 1'b1;
                if (r_fill_addr == SINE_ADDR_BITS'(SINE_DEPTH - 1)) begin
                    r_filling <= 1'b0;
                end
            end
            r_phase    <= n_phase;
            r_incr     <= n_incr;
            r_left     <= n_left;
            r_rd_valid <= issue;
        end
    end

    // Side information that travels with the table read
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_neg  <= quad[1];
            r_rd_max  <= quad[0] && (idx == '0);
            r_rd_last <= (r_left == COUNT_BITS'(1));
        end
    end

    // Form the signed sample from the table magnitude
    always_comb begin
        mag    = r_rd_max ? AMPLITUDE : $signed(rom_data);
        sample = r_rd_neg ? -mag : mag;
    end

    // Output buffer storage
    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_ob_sample[r_ob_wptr] <= sample;
            r_ob_last[r_ob_wptr]   <= r_rd_last;
        end
    end

    // Output buffer pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wptr <= 1'b0;
            r_ob_rptr <= 1'b0;
            r_ob_cnt  <= '0;
        end else begin
            if (r_rd_valid) begin
                r_ob_wptr <= !r_ob_wptr;
            end
            if (ob_pop) begin
                r_ob_rptr <= !r_ob_rptr;
            end
            r_ob_cnt <= r_ob_cnt + 2'(r_rd_valid) - 2'(ob_pop);
        end
    end

    assign o_valid        = (r_ob_cnt != '0);
    assign o_sample       = r_ob_sample[r_ob_rptr];
    assign o_last_of_tone = r_ob_last[r_ob_rptr];

    a_obuf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt <= 2'(OBUF_DEPTH))
        else $error("output buffer count out of range");

    a_obuf_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ob_cnt == 2'(OBUF_DEPTH) && !ob_pop) |-> !r_rd_valid)
        else $error("table read landed on a full output buffer");

    a_issue_has_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (r_left != '0) && !r_filling)
        else $error("sample issued with no samples left or during table load");

    a_last_ends_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && r_left == COUNT_BITS'(1)) |=> (r_left == '0) || $past(o_q_pop))
        else $error("final sample issued but count did not reach zero");

endmodule
